// ===== rtl/assert_macros.svh =====
// assertion macros used by rtl/modular_exponentiation.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== rtl/modexp_pkg.sv =====
// shared widths, constants and the command type of the multiply-reduce unit
// no dependencies
package modexp_pkg;

  localparam int MOD_W     = 31;
  localparam int BASE_W    = 63;
  localparam int EXP_BITS  = 63;
  localparam int CNT_W     = $clog2(BASE_W + 1);
  localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(1000000007);

  // one job for the multiply-reduce unit: bits of x are shifted in msb first
  typedef struct packed {
    logic [MOD_W-1:0]  addend;
    logic [BASE_W-1:0] x;
    logic [CNT_W-1:0]  nbits;
    logic              reduce;
  } mmu_cmd_t;

endpackage

// ===== rtl/modular_exponentiation.sv =====
// modular exponentiation: base ** exponent mod modulus
// depends on modexp_pkg, modexp_mmu and assert_macros.svh
//
// usage
//   input words (base, exponent) arrive on in_valid / in_stall and are taken
//   when in_valid is high and in_stall low. one result word (power_result)
//   leaves on out_valid / out_stall, taken when out_stall is low. the user
//   must write the modulus (cfg_wen / cfg_wdata) only while idle; unchecked.
// sequence
//   one word at a time, set by the bit-serial multiply-reduce unit. the base
//   is reduced first, then each exponent bit up to the highest set one takes
//   a step state, a multiply for a set bit and a squaring (no squaring after
//   the highest bit), then the result is loaded into the output register.
//   a modulus below two or a base that reduces to zero goes straight to the
//   output load with a zero result. the next word can be taken in the cycle
//   after the result is loaded.
// reset and stall
//   reset empties the block and loads the modulus with 1000000007. a stalled
//   result stays in the output register; the next word is taken meanwhile
//   and its result waits until the output register is free.
`include "assert_macros.svh"

module modular_exponentiation
  import modexp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [MOD_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BASE_W-1:0] base,
  input  logic [BASE_W-1:0] exponent,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [MOD_W-1:0]  power_result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_STEP,
    S_MUL,
    S_SQR,
    S_OUT
  } state_t;

  state_t              state;
  logic [MOD_W-1:0]    modulus;
  logic [MOD_W-1:0]    mod_q;
  logic [EXP_BITS-1:0] exp;
  logic [MOD_W-1:0]    acc;
  logic [MOD_W-1:0]    sq;
  logic                u_start;
  mmu_cmd_t            u_cmd;
  logic                u_busy;
  logic                u_done;
  logic [MOD_W-1:0]    u_res;
  logic                in_take;
  logic                more_bits;
  logic                unit_op;

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign more_bits = (exp[EXP_BITS-1:1] != '0);
  assign unit_op   = (state == S_MUL) || (state == S_SQR);

  // modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_RESET;
    end else if (cfg_wen) begin
      modulus <= cfg_wdata;
    end
  end

  // shared multiply-reduce unit
  modexp_mmu u_mmu (
    .clk     (clk),
    .rst     (rst),
    .start   (u_start),
    .cmd     (u_cmd),
    .modulus (mod_q),
    .busy    (u_busy),
    .done    (u_done),
    .result  (u_res)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      u_start   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      u_start <= 1'b0;
      // word taken; S_OUT reloads the output register itself
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            mod_q <= modulus;
            exp   <= exponent[EXP_BITS-1:0];
            if (modulus < MOD_W'(2)) begin
              acc   <= '0;
              state <= S_OUT;
            end else begin
              acc          <= MOD_W'(1);
              u_cmd.addend <= '0;
              u_cmd.x      <= base;
              u_cmd.nbits  <= CNT_W'(BASE_W);
              u_cmd.reduce <= 1'b1;
              u_start      <= 1'b1;
              state        <= S_RED;
            end
          end
        end
        S_RED: begin
          if (u_done) begin
            sq <= u_res;
            if (u_res == '0) begin
              acc   <= '0;
              state <= S_OUT;
            end else begin
              state <= S_STEP;
            end
          end
        end
        S_STEP: begin
          if (exp[0]) begin
            u_cmd.addend <= acc;
            u_cmd.x      <= {sq, {(BASE_W - MOD_W){1'b0}}};
            u_cmd.nbits  <= CNT_W'(MOD_W);
            u_cmd.reduce <= 1'b0;
            u_start      <= 1'b1;
            state        <= S_MUL;
          end else if (more_bits) begin
            u_cmd.addend <= sq;
            u_cmd.x      <= {sq, {(BASE_W - MOD_W){1'b0}}};
            u_cmd.nbits  <= CNT_W'(MOD_W);
            u_cmd.reduce <= 1'b0;
            u_start      <= 1'b1;
            state        <= S_SQR;
          end else begin
            state <= S_OUT;
          end
        end
        S_MUL: begin
          if (u_done) begin
            acc <= u_res;
            if (more_bits) begin
              u_cmd.addend <= sq;
              u_cmd.x      <= {sq, {(BASE_W - MOD_W){1'b0}}};
              u_cmd.nbits  <= CNT_W'(MOD_W);
              u_cmd.reduce <= 1'b0;
              u_start      <= 1'b1;
              state        <= S_SQR;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_SQR: begin
          if (u_done) begin
            sq    <= u_res;
            exp   <= {1'b0, exp[EXP_BITS-1:1]};
            state <= S_STEP;
          end
        end
        S_OUT: begin
          // hand the word over once the output register is free
          if (!out_valid || !out_stall) begin
            power_result <= acc;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `ASSERT_CLK(a_start_idle_unit, clk, rst, u_start |-> !u_busy, "unit started while busy")
  `ASSERT_NEVER(a_take_while_busy, clk, rst, !in_stall && u_busy, "input open while unit busy")
  `ASSERT_CLK(a_ops_reduced, clk, rst, unit_op |-> acc < mod_q && sq < mod_q, "unreduced operand")

endmodule

// ===== rtl/modexp_mmu.sv =====
// bit-serial modular multiply / reduce unit, one operand bit per cycle
// depends on modexp_pkg
module modexp_mmu
  import modexp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  mmu_cmd_t         cmd,
  input  logic [MOD_W-1:0] modulus,
  output logic             busy,
  output logic             done,
  output logic [MOD_W-1:0] result
);

  logic [BASE_W-1:0] sh;
  logic [CNT_W-1:0]  cnt;
  logic [MOD_W-1:0]  addend;
  logic              reduce;

  logic [MOD_W:0]   dbl;
  logic [MOD_W:0]   dbl_sub;
  logic [MOD_W-1:0] r_dbl;
  logic [MOD_W-1:0] add_val;
  logic [MOD_W:0]   sum;
  logic [MOD_W:0]   sum_sub;
  logic [MOD_W-1:0] result_next;

  // r = (2r + bit*addend) mod m, addend 1 if reduce; two compare-subtracts
  always_comb begin
    dbl     = {result, 1'b0};
    dbl_sub = dbl - {1'b0, modulus};
    r_dbl   = (dbl >= {1'b0, modulus}) ? dbl_sub[MOD_W-1:0] : dbl[MOD_W-1:0];
    if (!sh[BASE_W-1]) begin
      add_val = '0;
    end else if (reduce) begin
      add_val = MOD_W'(1);
    end else begin
      add_val = addend;
    end
    sum         = {1'b0, r_dbl} + {1'b0, add_val};
    sum_sub     = sum - {1'b0, modulus};
    result_next = (sum >= {1'b0, modulus}) ? sum_sub[MOD_W-1:0] : sum[MOD_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= cmd.nbits;
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      sh     <= cmd.x;
      addend <= cmd.addend;
      reduce <= cmd.reduce;
      result <= '0;
    end else if (busy) begin
      sh     <= {sh[BASE_W-2:0], 1'b0};
      result <= result_next;
    end
  end

endmodule
